// ===== sv/bra_pkg.sv =====
// Shared constants and types of the bitmap run allocator.
package bra_pkg;

  localparam int WORD_BITS     = 32;
  localparam int OFF_W         = 5;
  localparam int BIT_W         = 12;
  localparam int COUNT_W       = 11;
  localparam int START_W       = 10;
  localparam int CFG_W         = 6;
  localparam int LEN_W         = 6;
  localparam int MAP_WORDS_DEF = 32;
  localparam int WIU_RESET     = 32;

  localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_ZERO    = 2'd2
  } status_t;

  typedef struct packed {
    logic             used;
    logic [LEN_W-1:0] len;
  } span_t;

endpackage

// ===== sv/bitmap_run_allocator.sv =====
// Top level of the first-fit bitmap run allocator.
//
//   channel   dir  fields (low bit up)                          handshake
//   s_*       in   tdata: bit_count[10:0], start_bit[20:11]     tvalid/tready
//                  tuser: kind[0]
//   m_*       out  tdata: granted_bit[9:0]                      tvalid/tready
//                  tuser: status[1:0]
//   cfg_*     in   cfg_wdata: words_in_use[5:0]                 cfg_we
//
// After reset the bitmap is cleared one word a cycle, with s_tready low until it is done.
// Allocate: each scanned word is read and walked stretch by stretch of free or used bits, then
// each word of the granted run is read and written back. Free: each word touched likewise.
// Zero counts, frees past the map, and allocations with no open word or too long answer from idle.
// One bitmap read port and one stretch finder set the pace; one item is in work at a time.
// The result is held in an output register until taken; a new beat is taken with it.
module bitmap_run_allocator #(
  parameter int MAP_WORDS = bra_pkg::MAP_WORDS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [23:0]              s_tdata,   // bit_count[10:0], start_bit[20:11]
  input  logic [0:0]               s_tuser,   // kind[0]
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [15:0]              m_tdata,   // granted_bit[9:0]
  output logic [1:0]               m_tuser,   // status[1:0]
  input  logic                     cfg_we,
  input  logic [bra_pkg::CFG_W-1:0] cfg_wdata
);
  import bra_pkg::*;

  localparam int WORD_AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int HINT_W  = $clog2(MAP_WORDS + 1);
  localparam int ACT_MAX = (MAP_WORDS < 63) ? MAP_WORDS : 63;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_MRD   = 6'b010000,
    S_MWR   = 6'b100000
  } state_t;

  state_t               state;
  logic [WORD_AW-1:0]   clr_addr;
  logic [CFG_W-1:0]     words_in_use;
  logic [HINT_W-1:0]    hint;
  logic                 lead;
  logic                 set_mode;
  logic [BIT_W-1:0]     pos;
  logic [BIT_W-1:0]     run_end;
  logic [BIT_W-1:0]     run_start;
  logic [COUNT_W-1:0]   count_q;
  logic [COUNT_W-1:0]   run;
  logic [WORD_BITS-1:0] rd_data;
  status_t              out_status;
  logic [START_W-1:0]   out_granted;

  logic [WORD_BITS-1:0] bitmap [MAP_WORDS];

  logic                 s_kind;
  logic [COUNT_W-1:0]   s_count;
  logic [START_W-1:0]   s_start;
  logic [CFG_W-1:0]     active;
  logic [BIT_W-1:0]     total;
  logic [BIT_W-1:0]     req_end;
  logic [BIT_W-1:0]     free_end;
  logic [BIT_W-1:0]     alloc_base;
  logic [WORD_AW-1:0]   pos_word;
  span_t                span;
  logic [BIT_W-1:0]     pos_step;
  logic [BIT_W-1:0]     run_sum;
  logic [BIT_W-1:0]     rs;
  logic [BIT_W-1:0]     word_base;
  logic [BIT_W-1:0]     next_base;
  logic [WORD_BITS-1:0] mask;
  logic                 rd_en;
  logic                 wr_en;
  logic [WORD_AW-1:0]   wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  assign s_kind  = s_tuser[0];
  assign s_count = s_tdata[10:0];
  assign s_start = s_tdata[20:11];

  assign active     = (words_in_use > CFG_W'(ACT_MAX)) ? CFG_W'(ACT_MAX) : words_in_use;
  assign total      = BIT_W'({active, {OFF_W{1'b0}}});
  assign req_end    = BIT_W'(s_count) + BIT_W'(s_start);
  assign free_end   = (req_end > total) ? total : req_end;
  assign alloc_base = BIT_W'({hint, {OFF_W{1'b0}}});
  assign pos_word   = WORD_AW'(pos[BIT_W-1:OFF_W]);

  bra_span u_span (
    .word (rd_data),
    .off  (pos[OFF_W-1:0]),
    .span (span)
  );

  assign pos_step  = pos + BIT_W'(span.len);
  assign run_sum   = BIT_W'(run) + BIT_W'(span.len);
  assign rs        = (run == '0) ? pos : run_start;
  assign word_base = {pos[BIT_W-1:OFF_W], {OFF_W{1'b0}}};
  assign next_base = word_base + BIT_W'(WORD_BITS);

  always_comb begin
    mask = FULL_WORD << pos[OFF_W-1:0];
    if (run_end < next_base) begin
      mask = mask & ~(FULL_WORD << run_end[OFF_W-1:0]);
    end
  end

  assign rd_en   = (state == S_READ) || (state == S_MRD);
  assign wr_en   = (state == S_CLEAR) || (state == S_MWR);
  assign wr_addr = (state == S_CLEAR) ? clr_addr : pos_word;
  assign wr_data = (state == S_CLEAR) ? '0 :
                   set_mode ? (rd_data | mask) : (rd_data & ~mask);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bitmap[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= bitmap[pos_word];
    end
  end

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      hint         <= '0;
      lead         <= 1'b0;
      words_in_use <= CFG_W'(WIU_RESET);
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        words_in_use <= cfg_wdata;
      end
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == WORD_AW'(MAP_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            count_q  <= s_count;
            set_mode <= (s_kind == KIND_ALLOC);
            run      <= '0;
            if (s_count == '0) begin
              out_status  <= ST_ZERO;
              out_granted <= '0;
              m_tvalid    <= 1'b1;
            end else if (s_kind == KIND_ALLOC) begin
              if ((BIT_W'(s_count) > total) || (32'(hint) >= 32'(active))) begin
                out_status  <= ST_NO_ROOM;
                out_granted <= '0;
                m_tvalid    <= 1'b1;
              end else begin
                pos   <= alloc_base;
                lead  <= 1'b1;
                state <= S_READ;
              end
            end else begin
              if (BIT_W'(s_start) >= total) begin
                out_status  <= ST_OK;
                out_granted <= '0;
                m_tvalid    <= 1'b1;
              end else begin
                pos     <= BIT_W'(s_start);
                run_end <= free_end;
                state   <= S_MRD;
                if (HINT_W'(s_start[START_W-1:OFF_W]) < hint) begin
                  hint <= HINT_W'(s_start[START_W-1:OFF_W]);
                end
              end
            end
          end
        end
        S_READ: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (lead) begin
            if ((pos[OFF_W-1:0] == '0) && span.used && (span.len == LEN_W'(WORD_BITS))) begin
              hint <= hint + 1'b1;
            end else begin
              lead <= 1'b0;
            end
          end
          if (!span.used && (run_sum >= BIT_W'(count_q))) begin
            pos       <= rs;
            run_start <= rs;
            run_end   <= rs + BIT_W'(count_q);
            lead      <= 1'b0;
            state     <= S_MRD;
          end else begin
            pos <= pos_step;
            if (span.used) begin
              run <= '0;
            end else begin
              run       <= COUNT_W'(run_sum);
              run_start <= rs;
            end
            if (pos_step >= total) begin
              out_status  <= ST_NO_ROOM;
              out_granted <= '0;
              m_tvalid    <= 1'b1;
              lead        <= 1'b0;
              state       <= S_IDLE;
            end else if (pos_step[OFF_W-1:0] == '0) begin
              state <= S_READ;
            end
          end
        end
        S_MRD: begin
          state <= S_MWR;
        end
        S_MWR: begin
          if (next_base >= run_end) begin
            out_status  <= ST_OK;
            out_granted <= set_mode ? START_W'(run_start) : '0;
            m_tvalid    <= 1'b1;
            state       <= S_IDLE;
          end else begin
            pos   <= next_base;
            state <= S_MRD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {{(16 - START_W){1'b0}}, out_granted};
  assign m_tuser = out_status;

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (pos < total))
    else $error("scan position beyond managed bits");

  a_hint_bound: assert property (@(posedge clk) disable iff (rst)
    32'(hint) <= MAP_WORDS)
    else $error("open word hint beyond map");

  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == '0))
    else $error("granted index on failed request");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_tready)
    else $error("beat taken during bitmap clear");

endmodule

// ===== sv/bra_span.sv =====
// Stretch finder: kind and length of the stretch of equal bits at an offset of a word.
module bra_span (
  input  logic [bra_pkg::WORD_BITS-1:0] word,
  input  logic [bra_pkg::OFF_W-1:0]     off,
  output bra_pkg::span_t                span
);
  import bra_pkg::*;

  logic [WORD_BITS-1:0] shifted;
  logic [WORD_BITS-1:0] live;
  logic [WORD_BITS-1:0] stop;

  always_comb begin
    shifted   = word >> off;
    live      = FULL_WORD >> off;
    span.used = shifted[0];
    stop      = shifted[0] ? ~shifted : (shifted | ~live);
    span.len  = LEN_W'(WORD_BITS);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (stop[i]) begin
        span.len = LEN_W'(i);
      end
    end
  end

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for bitmap_run_allocator: stream stimulus checked against a shadow bitmap.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bra_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SHADOW_WORDS   = MAP_WORDS_DEF;

  typedef struct {
    status_t            status;
    logic [START_W-1:0] granted;
  } grant_t;

  typedef struct {
    int lo;
    int len;
  } run_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [23:0]          s_tdata   = '0;  // bit_count[10:0], start_bit[20:11]
  logic [0:0]           s_tuser   = '0;  // kind[0]
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [15:0]          m_tdata;         // granted_bit[9:0]
  logic [1:0]           m_tuser;         // status[1:0]
  logic                 cfg_we    = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  logic [WORD_BITS-1:0] shadow_map [SHADOW_WORDS] = '{default: '0};
  logic [CFG_W-1:0]     shadow_words = CFG_W'(WIU_RESET);
  grant_t               pending_results [$];
  run_t                 live_runs [$];
  int                   error_count     = 0;
  bit                   gaps_on         = 1'b1;
  int                   rx_hold_request = 0;

  bitmap_run_allocator #(
    .MAP_WORDS(MAP_WORDS_DEF)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic grant_t apply_request(input logic kind, input logic [COUNT_W-1:0] count,
                                           input logic [START_W-1:0] start);
    grant_t res;
    int     total;
    int     run;
    int     run_start;
    int     n;
    int     lo;
    bit     found;
    res.status  = ST_OK;
    res.granted = '0;
    n           = int'(count);
    lo          = int'(start);
    total = ((shadow_words > SHADOW_WORDS) ? SHADOW_WORDS : int'(shadow_words)) * WORD_BITS;
    if (n == 0) begin
      res.status = ST_ZERO;
    end else if (kind == KIND_ALLOC) begin
      res.status = ST_NO_ROOM;
      run        = 0;
      run_start  = 0;
      found      = 1'b0;
      if (n <= total) begin
        for (int b = 0; b < total && !found; b++) begin
          if (shadow_map[b / WORD_BITS][b % WORD_BITS]) begin
            run = 0;
          end else begin
            if (run == 0) run_start = b;
            run++;
            if (run == n) found = 1'b1;
          end
        end
      end
      if (found) begin
        for (int b = run_start; b < run_start + n; b++)
          shadow_map[b / WORD_BITS][b % WORD_BITS] = 1'b1;
        res.status  = ST_OK;
        res.granted = START_W'(run_start);
      end
    end else begin
      for (int b = lo; b < lo + n && b < total; b++)
        shadow_map[b / WORD_BITS][b % WORD_BITS] = 1'b0;
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 60) return COUNT_W'($urandom_range(1, 8));
    if (r < 85) return COUNT_W'($urandom_range(9, 64));
    if (r < 95) return COUNT_W'($urandom_range(65, 300));
    if (r < 99) return COUNT_W'($urandom_range(301, 1024));
    return COUNT_W'($urandom_range(1025, 2047));
  endfunction

  task automatic send_request(input logic kind, input logic [COUNT_W-1:0] count,
                              input logic [START_W-1:0] start);
    int     gap;
    grant_t res;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {3'b000, start, count};
    do @(posedge clk); while (!s_tready);
    res = apply_request(kind, count, start);
    pending_results.push_back(res);
    if (kind == KIND_ALLOC && res.status == ST_OK)
      live_runs.push_back('{int'(res.granted), int'(count)});
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_words_in_use(input int value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    cfg_we       <= 1'b0;
    shadow_words = CFG_W'(value);
  endtask

  task automatic test_directed_cases();
    send_request(KIND_ALLOC, 11'd0, 10'd0);
    send_request(KIND_FREE, 11'd0, 10'd1023);
    send_request(KIND_ALLOC, 11'd1, 10'd1023);
    send_request(KIND_ALLOC, 11'd31, 10'd0);
    send_request(KIND_ALLOC, 11'd33, 10'd0);
    send_request(KIND_ALLOC, 11'd2047, 10'd0);
    send_request(KIND_ALLOC, 11'd1024, 10'd0);
    send_request(KIND_FREE, 11'd1, 10'd0);
    send_request(KIND_ALLOC, 11'd1, 10'd0);
    send_request(KIND_FREE, 11'd1024, 10'd0);
    send_request(KIND_ALLOC, 11'd1024, 10'd0);
    send_request(KIND_ALLOC, 11'd1, 10'd0);
    send_request(KIND_FREE, 11'd2047, 10'd1023);
    send_request(KIND_ALLOC, 11'd1, 10'd0);
    send_request(KIND_FREE, 11'd10, 10'd500);
    send_request(KIND_FREE, 11'd10, 10'd500);
    send_request(KIND_ALLOC, 11'd10, 10'd0);
    send_request(KIND_FREE, 11'd1024, 10'd0);
    live_runs.delete();
  endtask

  task automatic test_map_sizes();
    write_words_in_use(0);
    send_request(KIND_ALLOC, 11'd1, 10'd0);
    send_request(KIND_FREE, 11'd5, 10'd0);
    write_words_in_use(32);
    send_request(KIND_ALLOC, 11'd64, 10'd0);
    write_words_in_use(1);
    send_request(KIND_FREE, 11'd64, 10'd0);
    send_request(KIND_ALLOC, 11'd33, 10'd0);
    send_request(KIND_ALLOC, 11'd32, 10'd0);
    send_request(KIND_ALLOC, 11'd1, 10'd0);
    write_words_in_use(63);
    send_request(KIND_ALLOC, 11'd1, 10'd0);
    write_words_in_use(32);
    send_request(KIND_FREE, 11'd1024, 10'd0);
    live_runs.delete();
  endtask

  task automatic test_output_backpressure();
    settle();
    gaps_on         = 1'b0;
    rx_hold_request = 400;
    repeat (12) send_request(KIND_ALLOC, COUNT_W'($urandom_range(1, 16)), START_W'($urandom));
    gaps_on = 1'b1;
    settle();
  endtask

  task automatic random_item();
    int                 sel;
    int                 idx;
    run_t               r;
    logic [START_W-1:0] st;
    sel = $urandom_range(99);
    st  = START_W'($urandom);
    if (sel < ((live_runs.size() < 24) ? 60 : 35)) begin
      send_request(KIND_ALLOC, pick_count(), st);
    end else if (sel < 88 && live_runs.size() != 0) begin
      idx = $urandom_range(live_runs.size() - 1);
      r   = live_runs[idx];
      live_runs.delete(idx);
      if ($urandom_range(4) == 0 && r.len > 1)
        send_request(KIND_FREE, COUNT_W'($urandom_range(1, r.len - 1)), START_W'(r.lo));
      else
        send_request(KIND_FREE, COUNT_W'(r.len), START_W'(r.lo));
    end else if (sel < 96) begin
      send_request(KIND_FREE, pick_count(), st);
    end else begin
      send_request(($urandom_range(1) == 1) ? KIND_FREE : KIND_ALLOC, '0, st);
    end
  endtask

  task automatic test_random_traffic(input int n_items);
    int plan [6] = '{32, 7, 63, 1, 20, 32};
    for (int p = 0; p < 6; p++) begin
      write_words_in_use(plan[p]);
      gaps_on = (p != 2);
      repeat (n_items / 6) random_item();
    end
    gaps_on = 1'b1;
  endtask

  initial begin : result_monitor
    int     rx_left;
    grant_t exp_res;
    rx_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          error_count++;
          $error("result beat with no request pending: status %0d granted_bit %0d",
                 m_tuser, m_tdata[9:0]);
        end else begin
          exp_res = pending_results.pop_front();
          if (m_tuser !== exp_res.status) begin
            error_count++;
            $error("status: expected %0d, got %0d", exp_res.status, m_tuser);
          end
          if (m_tdata[9:0] !== exp_res.granted) begin
            error_count++;
            $error("granted_bit: expected %0d, got %0d", exp_res.granted, m_tdata[9:0]);
          end
        end
      end
      if (rx_hold_request > 0) begin
        rx_left         = rx_hold_request;
        rx_hold_request = 0;
      end
      if (rx_left > 0) begin
        m_tready <= 1'b0;
        rx_left--;
      end else begin
        m_tready <= 1'b1;
        rx_left  = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_map_sizes();
    test_output_backpressure();
    test_random_traffic(1300);
    settle();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/bra_pkg.sv
sv/bra_span.sv
sv/bitmap_run_allocator.sv
bench/tb.sv
